@@ design/bgc_pkg.sv @@
package bgc_pkg;

  // vertex colour codes
  typedef enum logic [1:0] {
    COL_NONE = 2'd0,
    COL_ONE  = 2'd1,
    COL_TWO  = 2'd2
  } colour_e;

  localparam int unsigned CfgWidth    = 11;
  localparam int unsigned VertexWidth = 10;

endpackage

@@ design/bgc_mem.sv @@
module bgc_mem #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write one word, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/bipartite_graph_check.sv @@
// Edge load: one word a cycle while stall is low, which it is only in the load state.
// The word marked last starts the search, which scans vertices, visits the stack and
// examines edges; an input error skips the search and goes straight to the result.
// Once the result is taken a clearing pass wipes all MAX_VERTICES colour words
// before the next word; reset (asynchronous, active low) runs the same pass, count to 1.
module bipartite_graph_check #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgc_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          edge_valid_i,
  input  logic [bgc_pkg::VertexWidth-1:0] from_vertex_i,
  input  logic [bgc_pkg::VertexWidth-1:0] to_vertex_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_bipartite_o,
  output logic                          input_error_o
);
  import bgc_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned ET = $clog2(MAX_EDGES + 1);
  localparam int unsigned TW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NW = (CfgWidth > TW) ? CfgWidth : TW;
  localparam int unsigned SW = VW + ET;

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_SCAN, S_SCAN_W, S_TOP, S_TOP_W, S_EDGE, S_EDGE_W,
    S_COLW, S_COLW_W, S_PUSH, S_DONE, S_OUT
  } state_e;

  state_e state_q;
  logic [CfgWidth-1:0] vcount_q;
  logic [ET-1:0] etotal_q;
  logic          err_q, ok_q;
  logic [TW-1:0] top_q;
  logic [NW-1:0] scan_q;
  logic [VW-1:0] v_q, w_q;
  logic [ET-1:0] e_q;
  logic [1:0]    vcol_q;

  // vertices in use
  logic [NW-1:0] n_use;
  always_comb begin
    if (NW'(vcount_q) < NW'(MAX_VERTICES)) n_use = NW'(vcount_q);
    else n_use = NW'(MAX_VERTICES);
  end

  // memories
  logic          ed_we, cl_we, st_we;
  logic [EW-1:0] ed_wa, ed_ra;
  logic [2*VW-1:0] ed_wd, ed_rd;
  logic [VW-1:0] cl_wa, cl_ra;
  logic [1:0]    cl_wd, cl_rd;
  logic [VW-1:0] st_wa, st_ra;
  logic [SW-1:0] st_wd, st_rd;

  bgc_mem #(.Width(2*VW), .Depth(MAX_EDGES)) u_edges (
    .clk_i, .we_i(ed_we), .waddr_i(ed_wa), .wdata_i(ed_wd),
    .raddr_i(ed_ra), .rdata_o(ed_rd));
  bgc_mem #(.Width(2), .Depth(MAX_VERTICES)) u_colour (
    .clk_i, .we_i(cl_we), .waddr_i(cl_wa), .wdata_i(cl_wd),
    .raddr_i(cl_ra), .rdata_o(cl_rd));
  bgc_mem #(.Width(SW), .Depth(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd));

  logic accept;
  logic a_bad, b_bad;
  assign in_stall_o = (state_q != S_LOAD);
  assign accept     = in_valid_i && !in_stall_o;
  assign a_bad = ({{(NW > VertexWidth ? NW-VertexWidth : 0){1'b0}}, from_vertex_i} >= n_use);
  assign b_bad = ({{(NW > VertexWidth ? NW-VertexWidth : 0){1'b0}}, to_vertex_i} >= n_use);

  logic [VW-1:0] e_from, e_to;
  assign e_from = ed_rd[2*VW-1:VW];
  assign e_to   = ed_rd[VW-1:0];
  logic [VW-1:0] s_v;
  logic [ET-1:0] s_e;
  assign s_v = st_rd[SW-1:ET];
  assign s_e = st_rd[ET-1:0];
  logic [TW-1:0] top_m1;
  assign top_m1 = top_q - TW'(1);

  // memory ports
  always_comb begin
    ed_we = accept && edge_valid_i && !a_bad && !b_bad && (etotal_q < ET'(MAX_EDGES));
    ed_wa = etotal_q[EW-1:0];
    ed_wd = {VW'(from_vertex_i), VW'(to_vertex_i)};
    ed_ra = e_q[EW-1:0];
    cl_we = 1'b0;
    cl_wa = w_q;
    cl_wd = 2'd3 - vcol_q;
    cl_ra = w_q;
    st_we = 1'b0;
    st_wa = top_q[VW-1:0];
    st_wd = {w_q, ET'(0)};
    st_ra = top_m1[VW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        cl_we = 1'b1; cl_wa = scan_q[VW-1:0]; cl_wd = COL_NONE;
      end
      S_SCAN: cl_ra = scan_q[VW-1:0];
      S_SCAN_W: begin
        cl_wa = scan_q[VW-1:0]; cl_wd = COL_ONE;
        st_wa = '0; st_wd = {scan_q[VW-1:0], ET'(0)};
        cl_we = (cl_rd == COL_NONE);
        st_we = (cl_rd == COL_NONE);
      end
      // stack word is valid here, so fetch the colour of its vertex
      S_TOP_W: cl_ra = s_v;
      S_EDGE: begin
        st_we = (e_q < etotal_q);
        st_wa = top_m1[VW-1:0];
        st_wd = {v_q, e_q + ET'(1)};
      end
      S_COLW: cl_ra = w_q;
      S_PUSH: begin
        cl_we = 1'b1;
        st_we = (top_q < TW'(MAX_VERTICES));
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      vcount_q <= CfgWidth'(1);
      etotal_q <= '0;
      err_q    <= 1'b0;
      ok_q     <= 1'b0;
      top_q    <= '0;
      scan_q   <= '0;
      v_q      <= '0;
      w_q      <= '0;
      e_q      <= '0;
      vcol_q   <= '0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      unique case (state_q)
        S_LOAD: if (accept) begin
          if (edge_valid_i) begin
            if (a_bad || b_bad || etotal_q >= ET'(MAX_EDGES)) err_q <= 1'b1;
            else etotal_q <= etotal_q + ET'(1);
          end
          if (last_edge_i) begin
            scan_q <= '0;
            ok_q   <= 1'b1;
            state_q <= (edge_valid_i && (a_bad || b_bad || etotal_q >= ET'(MAX_EDGES)))
                       || err_q ? S_DONE : S_SCAN;
          end
        end
        S_CLEAR: begin
          // wipe one colour word a cycle
          if (scan_q == NW'(MAX_VERTICES - 1)) begin
            scan_q <= '0; state_q <= S_LOAD;
          end else scan_q <= scan_q + NW'(1);
        end
        S_SCAN: state_q <= (scan_q >= n_use) ? S_DONE : S_SCAN_W;
        S_SCAN_W: begin
          if (cl_rd == COL_NONE) begin
            top_q <= TW'(1); state_q <= S_TOP;
          end else state_q <= S_SCAN;
          scan_q <= scan_q + NW'(1);
        end
        S_TOP: begin
          if (top_q == '0) state_q <= S_SCAN;
          else state_q <= S_TOP_W;
        end
        S_TOP_W: begin
          v_q <= s_v; e_q <= s_e;
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          vcol_q <= cl_rd;
          if (e_q >= etotal_q) begin
            top_q <= top_m1; state_q <= S_TOP;
          end else state_q <= S_EDGE_W;
        end
        S_EDGE_W: begin
          // pick neighbour across this edge
          if (e_from == v_q) begin
            w_q <= e_to; state_q <= S_COLW;
          end else if (e_to == v_q) begin
            w_q <= e_from; state_q <= S_COLW;
          end else state_q <= S_TOP;
        end
        S_COLW: state_q <= (NW'(w_q) >= n_use) ? S_TOP : S_COLW_W;
        S_COLW_W: begin
          if (cl_rd == COL_NONE) state_q <= S_PUSH;
          else if (cl_rd == vcol_q) begin
            ok_q <= 1'b0; state_q <= S_DONE;
          end else state_q <= S_TOP;
        end
        S_PUSH: begin
          if (top_q < TW'(MAX_VERTICES)) top_q <= top_q + TW'(1);
          state_q <= S_TOP;
        end
        S_DONE: state_q <= S_OUT;
        S_OUT: if (!out_stall_i) begin
          etotal_q <= '0; err_q <= 1'b0; scan_q <= '0;
          state_q  <= S_CLEAR;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign is_bipartite_o = ok_q && !err_q;
  assign input_error_o  = err_q;

  // checks
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result waits");
  a_err_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && input_error_o) |-> !is_bipartite_o) else $error("error not forced");
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(MAX_VERTICES)) else $error("stack overrun");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etotal_q <= ET'(MAX_EDGES)) else $error("edge count overrun");

endmodule
